@@ rtl/core/btlv_pkg.sv @@
// Shared types and constants of the BER-TLV stream parser.
`timescale 1ns / 1ps
`default_nettype none

package btlv_pkg;

    // Default width of the decoded length and of the value byte counter.
    localparam int LENGTH_BITS_DEF = 16;

    // Entries of the queue between the byte classifier and the parser.
    localparam int QUEUE_DEPTH = 4;

    // Tag escape: low five bits of the first tag byte all ones.
    localparam logic [4:0] TAG_ESCAPE = 5'h1f;
    // Bit of the first tag byte that marks a constructed element.
    localparam int CONSTRUCTED_BIT = 5;
    // Top bit of the first length byte selects the long form.
    localparam int LONG_FORM_BIT = 7;
    // Largest count of following length bytes that is supported.
    localparam logic [6:0] MAX_LEN_BYTES = 7'd2;

    typedef enum logic [2:0] {
        PH_TAG1  = 3'd0,
        PH_TAG2  = 3'd1,
        PH_LEN1  = 3'd2,
        PH_LENX  = 3'd3,
        PH_VALUE = 3'd4,
        PH_SKIP  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_VALUE     = 2'd1,
        KIND_TRUNCATED = 2'd2,
        KIND_LEN_LONG  = 2'd3
    } kind_t;

    // One buffer byte with its precomputed classification.
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        logic       tag_escape;
        logic       short_len;
        logic       len_cnt_zero;
        logic       len_too_long;
        logic [1:0] len_cnt;
    } btlv_byte_t;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] tag;
        logic [1:0]  tag_size;
        logic        constructed;
        logic [15:0] value_length;
        logic [1:0]  length_size;
        logic [7:0]  value_out;
        logic        element_end;
        logic        more_follows;
    } btlv_result_t;

endpackage

`default_nettype wire

@@ rtl/core/btlv_front.sv @@
// Input side: accept buffer bytes and classify them for the parser.
`timescale 1ns / 1ps
`default_nettype none

module btlv_front
    import btlv_pkg::*;
(
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,
    input  wire logic       s_axis_tlast,
    output logic            push_valid,
    output btlv_byte_t      push_item,
    input  wire logic       push_ready
);

    logic [6:0] len_cnt_full;

    assign len_cnt_full  = s_axis_tdata[6:0];
    assign s_axis_tready = push_ready;
    assign push_valid    = s_axis_tvalid;

    // Classify every byte for each role it could play; the parser picks by phase.
    always_comb begin
        push_item.data         = s_axis_tdata;
        push_item.eob          = s_axis_tlast;
        push_item.tag_escape   = (s_axis_tdata[4:0] == TAG_ESCAPE);
        push_item.short_len    = !s_axis_tdata[LONG_FORM_BIT];
        push_item.len_cnt_zero = (len_cnt_full == 7'd0);
        push_item.len_too_long = (len_cnt_full > MAX_LEN_BYTES);
        push_item.len_cnt      = len_cnt_full[1:0];
    end

endmodule

`default_nettype wire

@@ rtl/core/btlv_queue.sv @@
// Short queue of classified bytes between the front and the parser.
`timescale 1ns / 1ps
`default_nettype none

module btlv_queue
    import btlv_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    input  btlv_byte_t      push_item,
    output logic            push_ready,
    output logic            pop_valid,
    output btlv_byte_t      pop_item,
    input  wire logic       pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    btlv_byte_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/btlv_back.sv @@
// Parser: walk tag, length and value phases and register at most one result per byte.
`timescale 1ns / 1ps
`default_nettype none

module btlv_back
    import btlv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       pop_valid,
    input  btlv_byte_t      pop_item,
    output logic            pop_ready,
    output logic            out_valid,
    output btlv_result_t    out_result,
    input  wire logic       out_ready
);

    phase_t                 phase_reg, phase_next;
    logic [7:0]             first_tag_reg, first_tag_next;
    logic [15:0]            tag_reg, tag_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [1:0]             len_left_reg, len_left_next;
    logic [1:0]             len_count_reg, len_count_next;
    logic [LENGTH_BITS-1:0] val_left_reg, val_left_next;
    logic                   out_valid_reg, out_valid_next;
    btlv_result_t           out_reg;

    logic                   pop;
    logic                   emit;
    logic                   len_done;
    logic [LENGTH_BITS+7:0] acc_shifted;
    btlv_result_t           res;

    assign pop_ready   = !out_valid_reg || out_ready;
    assign pop         = pop_valid && pop_ready;
    assign acc_shifted = {acc_reg, pop_item.data};
    assign out_valid   = out_valid_reg;
    assign out_result  = out_reg;

    always_comb begin
        phase_next     = phase_reg;
        first_tag_next = first_tag_reg;
        tag_next       = tag_reg;
        acc_next       = acc_reg;
        len_left_next  = len_left_reg;
        len_count_next = len_count_reg;
        val_left_next  = val_left_reg;
        emit           = 1'b0;
        len_done       = 1'b0;
        res.kind         = KIND_HEADER;
        res.value_length = '0;
        res.value_out    = '0;
        res.element_end  = 1'b0;
        res.more_follows = 1'b0;

        if (pop) begin
            case (phase_reg)
                PH_TAG1: begin
                    first_tag_next = pop_item.data;
                    len_count_next = '0;
                    acc_next       = '0;
                    len_left_next  = '0;
                    val_left_next  = '0;
                    if (pop_item.tag_escape) begin
                        tag_next   = {pop_item.data, 8'h00};
                        phase_next = PH_TAG2;
                    end else begin
                        tag_next   = {8'h00, pop_item.data};
                        phase_next = PH_LEN1;
                    end
                    if (pop_item.eob) begin
                        emit       = 1'b1;
                        res.kind   = KIND_TRUNCATED;
                        phase_next = PH_TAG1;
                    end
                end
                PH_TAG2: begin
                    tag_next   = {first_tag_reg, pop_item.data};
                    phase_next = PH_LEN1;
                    if (pop_item.eob) begin
                        emit       = 1'b1;
                        res.kind   = KIND_TRUNCATED;
                        phase_next = PH_TAG1;
                    end
                end
                PH_LEN1: begin
                    len_count_next = 2'd1;
                    if (pop_item.short_len) begin
                        acc_next = LENGTH_BITS'(pop_item.data[6:0]);
                        len_done = 1'b1;
                    end else begin
                        acc_next = '0;
                        if (pop_item.len_cnt_zero) begin
                            len_done = 1'b1;
                        end else if (pop_item.len_too_long) begin
                            emit       = 1'b1;
                            res.kind   = KIND_LEN_LONG;
                            phase_next = pop_item.eob ? PH_TAG1 : PH_SKIP;
                        end else begin
                            len_left_next = pop_item.len_cnt;
                            phase_next    = PH_LENX;
                            if (pop_item.eob) begin
                                emit       = 1'b1;
                                res.kind   = KIND_TRUNCATED;
                                phase_next = PH_TAG1;
                            end
                        end
                    end
                end
                PH_LENX: begin
                    // Big-endian: shift the earlier bytes up.
                    acc_next       = acc_shifted[LENGTH_BITS-1:0];
                    len_count_next = len_count_reg + 2'd1;
                    len_left_next  = len_left_reg - 2'd1;
                    if (len_left_next == 2'd0) begin
                        len_done = 1'b1;
                    end else if (pop_item.eob) begin
                        emit       = 1'b1;
                        res.kind   = KIND_TRUNCATED;
                        phase_next = PH_TAG1;
                    end
                end
                PH_VALUE: begin
                    val_left_next = val_left_reg - LENGTH_BITS'(1);
                    if (val_left_next == '0) begin
                        emit             = 1'b1;
                        res.kind         = KIND_VALUE;
                        res.value_length = 16'(acc_reg);
                        res.value_out    = pop_item.data;
                        res.element_end  = 1'b1;
                        res.more_follows = !pop_item.eob;
                        phase_next       = PH_TAG1;
                    end else if (pop_item.eob) begin
                        emit       = 1'b1;
                        res.kind   = KIND_TRUNCATED;
                        phase_next = PH_TAG1;
                    end else begin
                        emit             = 1'b1;
                        res.kind         = KIND_VALUE;
                        res.value_length = 16'(acc_reg);
                        res.value_out    = pop_item.data;
                    end
                end
                default: begin
                    // Skip after an error up to and including the end mark.
                    phase_next = pop_item.eob ? PH_TAG1 : PH_SKIP;
                end
            endcase

            // Length field complete: close a zero-length element, flag a truncation, or open the value.
            if (len_done) begin
                emit = 1'b1;
                if (acc_next == '0) begin
                    res.kind         = KIND_HEADER;
                    res.element_end  = 1'b1;
                    res.more_follows = !pop_item.eob;
                    phase_next       = PH_TAG1;
                end else if (pop_item.eob) begin
                    res.kind   = KIND_TRUNCATED;
                    phase_next = PH_TAG1;
                end else begin
                    res.kind         = KIND_HEADER;
                    res.value_length = 16'(acc_next);
                    val_left_next    = acc_next;
                    phase_next       = PH_VALUE;
                end
            end
        end

        res.tag         = tag_next;
        res.tag_size    = (first_tag_next[4:0] == TAG_ESCAPE) ? 2'd2 : 2'd1;
        res.constructed = first_tag_next[CONSTRUCTED_BIT];
        res.length_size = len_count_next;

        if (pop && emit) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_TAG1;
            first_tag_reg <= '0;
            tag_reg       <= '0;
            acc_reg       <= '0;
            len_left_reg  <= '0;
            len_count_reg <= '0;
            val_left_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            first_tag_reg <= first_tag_next;
            tag_reg       <= tag_next;
            acc_reg       <= acc_next;
            len_left_reg  <= len_left_next;
            len_count_reg <= len_count_next;
            val_left_reg  <= val_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ber_tlv_stream_parser_core.sv @@
// Top level of the streaming BER-TLV element parser.
// Takes one buffer byte per transaction on the s_axis side (tlast marks the
// last byte of a buffer) and decodes a flat run of BER-TLV elements: one header
// transaction per element, then one transaction per value byte with tlast on
// the byte that ends the element. A first tag byte with low bits 0x1f pulls in
// a second tag byte; long-form lengths carry up to two big-endian bytes. A buffer
// that ends inside an element gives a truncated result; more than two length
// bytes give a length-too-long result, after which bytes are dropped up to the
// end mark. Bytes that produce nothing (tag bytes, length bytes, skipped bytes)
// give no m_axis transaction. The block sustains one byte per clock cycle while
// the queue is not full; a byte passes the queue before its result is registered. A
// four-entry queue between the byte classifier and the parser absorbs
// back-pressure, so s_axis_tready drops only once the queue is full.
`timescale 1ns / 1ps
`default_nettype none

module ber_tlv_stream_parser_core
    import btlv_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_of_buffer
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] tag, [17:16] tag_size, [18] constructed, [34:19] value_length,
    // [36:35] length_size, [44:37] value_out, [45] more_follows, [47:46] zero
    output logic [47:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast    // element_end
);

    logic         push_valid, push_ready;
    btlv_byte_t   push_item;
    logic         pop_valid, pop_ready;
    btlv_byte_t   pop_item;
    btlv_result_t result;

    // Front: accept and classify bytes.
    btlv_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .push_valid    (push_valid),
        .push_item     (push_item),
        .push_ready    (push_ready)
    );

    // Decouple the classifier from the parser and the output stalls.
    btlv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    // Back: advance the parse state and hold one result in the output register.
    btlv_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .out_valid  (m_axis_tvalid),
        .out_result (result),
        .out_ready  (m_axis_tready)
    );

    // Pack the result fields onto the stream bus.
    assign m_axis_tdata = {2'b00,
                           result.more_follows,
                           result.value_out,
                           result.length_size,
                           result.value_length,
                           result.constructed,
                           result.tag_size,
                           result.tag};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.element_end;

endmodule

`default_nettype wire

@@ dv/ber_tlv_stream_parser_core_tb.sv @@
// Self-checking testbench of the streaming BER-TLV element parser.
`timescale 1ns / 1ps

module ber_tlv_stream_parser_core_tb;
    import btlv_pkg::*;

    // Run limit: far beyond the slowest correct run (about 1k bytes, each
    // with the longest source gap and sink stall, plus the long hold-off).
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;
    localparam int RANDOM_BYTES = 750;
    // Cycles with nothing outstanding before a drain-marked byte is offered.
    localparam int DRAIN_CYCLES = 8;
    // Long sink hold-off: start point (bytes sent) and length in cycles.
    localparam int HOLD_AT_BYTE = 200;
    localparam int HOLD_CYCLES = 120;
    // Window of bytes sent with no idling on either side.
    localparam int QUIET_FROM = 300;
    localparam int QUIET_TO = 420;
    // Final stretch without idling.
    localparam int TAIL_BYTES = 120;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         hold_for_drain;
    } stream_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
    logic        s_axis_tlast = 1'b0;    // end_of_buffer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [15:0] tag, [17:16] tag_size, [18] constructed, [34:19] value_length,
    // [36:35] length_size, [44:37] value_out, [45] more_follows, [47:46] zero
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;           // kind
    logic        m_axis_tlast;           // element_end

    stream_byte_t byte_stream[$];
    stream_byte_t in_flight;
    btlv_result_t expected_results[$];
    logic [7:0]   frame_bytes[$];

    int stream_total = 0;
    int bytes_sent = 0;
    int mismatch_count = 0;
    logic sink_hold = 1'b0;

    // Parser state of the predictor.
    phase_t      tlv_phase = PH_TAG1;
    logic [7:0]  tag_first = 8'h00;
    logic [15:0] tag_acc = 16'h0000;
    logic [15:0] len_acc = 16'h0000;
    logic [1:0]  len_left = 2'd0;
    logic [1:0]  len_seen = 2'd0;
    logic [15:0] val_left = 16'h0000;

    ber_tlv_stream_parser_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Build a result from the element decoded so far.
    function automatic btlv_result_t make_result(input kind_t k, input logic [15:0] vlen,
                                                 input logic [7:0] vout, input logic endf,
                                                 input logic more);
        btlv_result_t r;
        r.kind         = k;
        r.tag          = tag_acc;
        r.tag_size     = (tag_first[4:0] == TAG_ESCAPE) ? 2'd2 : 2'd1;
        r.constructed  = tag_first[CONSTRUCTED_BIT];
        r.value_length = vlen;
        r.length_size  = len_seen;
        r.value_out    = vout;
        r.element_end  = endf;
        r.more_follows = more;
        return r;
    endfunction

    // End of the buffer inside an element: report it and restart on a new element.
    function automatic btlv_result_t truncate_element();
        tlv_phase = PH_TAG1;
        return make_result(KIND_TRUNCATED, 16'h0000, 8'h00, 1'b0, 1'b0);
    endfunction

    // Length field complete: close a zero-length element, truncate, or move to the value.
    function automatic btlv_result_t finish_length(input logic eob);
        if (len_acc == 16'h0000) begin
            tlv_phase = PH_TAG1;
            return make_result(KIND_HEADER, 16'h0000, 8'h00, 1'b1, !eob);
        end
        if (eob)
            return truncate_element();
        val_left = len_acc;
        tlv_phase = PH_VALUE;
        return make_result(KIND_HEADER, len_acc, 8'h00, 1'b0, 1'b0);
    endfunction

    // Advance the parser by one byte; return 1 when the byte yields a result.
    function automatic bit decode_byte(input logic [7:0] b, input logic eob,
                                       output btlv_result_t res);
        res = '0;
        case (tlv_phase)
            PH_TAG1: begin
                tag_first = b;
                len_seen  = 2'd0;
                len_acc   = 16'h0000;
                len_left  = 2'd0;
                val_left  = 16'h0000;
                if (b[4:0] == TAG_ESCAPE) begin
                    tag_acc   = {b, 8'h00};
                    tlv_phase = PH_TAG2;
                end else begin
                    tag_acc   = {8'h00, b};
                    tlv_phase = PH_LEN1;
                end
                if (eob) begin
                    res = truncate_element();
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_TAG2: begin
                tag_acc   = {tag_first, b};
                tlv_phase = PH_LEN1;
                if (eob) begin
                    res = truncate_element();
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_LEN1: begin
                len_seen = 2'd1;
                if (!b[LONG_FORM_BIT]) begin
                    len_acc = {8'h00, b};
                    res = finish_length(eob);
                    return 1'b1;
                end
                len_acc = 16'h0000;
                if (b[6:0] == 7'd0) begin
                    res = finish_length(eob);
                    return 1'b1;
                end
                if (b[6:0] > MAX_LEN_BYTES) begin
                    res = make_result(KIND_LEN_LONG, 16'h0000, 8'h00, 1'b0, 1'b0);
                    tlv_phase = eob ? PH_TAG1 : PH_SKIP;
                    return 1'b1;
                end
                len_left  = b[1:0];
                tlv_phase = PH_LENX;
                if (eob) begin
                    res = truncate_element();
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_LENX: begin
                // Big-endian: earlier bytes move up.
                len_acc  = {len_acc[7:0], b};
                len_seen = len_seen + 2'd1;
                len_left = len_left - 2'd1;
                if (len_left == 2'd0) begin
                    res = finish_length(eob);
                    return 1'b1;
                end
                if (eob) begin
                    res = truncate_element();
                    return 1'b1;
                end
                return 1'b0;
            end
            PH_VALUE: begin
                val_left = val_left - 16'd1;
                if (val_left == 16'h0000) begin
                    res = make_result(KIND_VALUE, len_acc, b, 1'b1, !eob);
                    tlv_phase = PH_TAG1;
                    return 1'b1;
                end
                if (eob) begin
                    res = truncate_element();
                    return 1'b1;
                end
                res = make_result(KIND_VALUE, len_acc, b, 1'b0, 1'b0);
                return 1'b1;
            end
            default: begin
                // Skip after a length-too-long error until the end mark.
                tlv_phase = eob ? PH_TAG1 : PH_SKIP;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] data, input logic last, input bit drain);
        stream_byte_t item;
        item.data = data;
        item.last = last;
        item.hold_for_drain = drain;
        byte_stream.push_back(item);
    endtask

    // Move the frame under construction to the stream, end mark on its last byte.
    task automatic flush_frame(input bit drain);
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            push_byte(frame_bytes[i], i == frame_bytes.size() - 1, drain && i == 0);
        frame_bytes.delete();
    endtask

    task automatic add_tag();
        logic [7:0] t1;
        t1 = 8'($urandom_range(0, 255));
        // Favor escaped tags so two-byte tags show up often.
        if ($urandom_range(0, 3) == 0)
            t1[4:0] = TAG_ESCAPE;
        frame_bytes.push_back(t1);
        if (t1[4:0] == TAG_ESCAPE)
            frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Append one element; a wild element has a random length byte and up to four random bytes.
    task automatic add_element(input bit wild);
        int sel;
        int len;
        add_tag();
        if (wild) begin
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        sel = $urandom_range(0, 127);
        if (sel < 80) begin
            len = (sel == 0) ? $urandom_range(6, 127) : $urandom_range(0, 5);
            frame_bytes.push_back(len[7:0]);
        end else if (sel < 92) begin
            len = 0;
            frame_bytes.push_back(8'h80);
        end else if (sel < 108) begin
            len = $urandom_range(0, 8);
            frame_bytes.push_back(8'h81);
            frame_bytes.push_back(len[7:0]);
        end else if (sel < 127) begin
            len = $urandom_range(0, 8);
            frame_bytes.push_back(8'h82);
            frame_bytes.push_back(8'h00);
            frame_bytes.push_back(len[7:0]);
        end else begin
            // Rare long value with a nonzero high length byte.
            len = $urandom_range(256, 300);
            frame_bytes.push_back(8'h82);
            frame_bytes.push_back(len[15:8]);
            frame_bytes.push_back(len[7:0]);
        end
        repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    function automatic bit idling_allowed(input int n);
        if (n >= QUIET_FROM && n < QUIET_TO)
            return 1'b0;
        return n < stream_total - TAIL_BYTES;
    endfunction

    // ------------------------------------------------------------------
    // Reset, stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int mode;
        int cut;
        int directed_n;

        // Escaped and constructed tag, one value byte, buffer goes on.
        push_byte(8'h3F, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0);
        // All-ones tag byte, long form with no following length bytes.
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0);
        // Tag zero, two big-endian length bytes, value extremes, end at element end.
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h82, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        // Three following length bytes: too long, then skip to the end mark.
        push_byte(8'h05, 1'b0, 1'b0);
        push_byte(8'h83, 1'b0, 1'b0);
        push_byte(8'h7E, 1'b1, 1'b0);
        // Buffer ends inside the value.
        push_byte(8'h06, 1'b0, 1'b0);
        push_byte(8'h03, 1'b0, 1'b0);
        push_byte(8'h01, 1'b1, 1'b0);
        // Buffer ends on an escaped first tag byte.
        push_byte(8'h1F, 1'b1, 1'b0);
        // Buffer ends after the first long-form length byte.
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'h81, 1'b1, 1'b0);
        // Buffer ends on a nonzero short length.
        push_byte(8'h02, 1'b0, 1'b0);
        push_byte(8'h05, 1'b1, 1'b0);
        directed_n = byte_stream.size();

        // Mostly well-formed buffers; the rest truncated, too long or noise.
        while (byte_stream.size() < directed_n + RANDOM_BYTES) begin
            mode = $urandom_range(0, 9);
            if (mode <= 6) begin
                repeat ($urandom_range(1, 4)) add_element(1'b0);
            end else if (mode == 7) begin
                repeat ($urandom_range(0, 2)) add_element(1'b0);
                add_element(1'($urandom_range(0, 1)));
                cut = $urandom_range(0, frame_bytes.size() - 1);
                while (frame_bytes.size() > cut + 1)
                    void'(frame_bytes.pop_back());
            end else if (mode == 8) begin
                add_tag();
                frame_bytes.push_back(8'($urandom_range(8'h83, 8'hFF)));
                repeat ($urandom_range(0, 5)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom_range(0, 255)));
            end
            // Hold the first random buffer until everything before it has drained.
            flush_frame(byte_stream.size() == directed_n);
        end
        stream_total = byte_stream.size();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_stream.size() != 0 || s_axis_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: offer queued bytes, predict on each accepted transaction
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : drive_bytes
        btlv_result_t res;
        bit produced;
        int src_gap;
        int quiet_cycles;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
            src_gap = 0;
            quiet_cycles = 0;
            tlv_phase = PH_TAG1;
            tag_first = 8'h00;
            tag_acc   = 16'h0000;
            len_acc   = 16'h0000;
            len_left  = 2'd0;
            len_seen  = 2'd0;
            val_left  = 16'h0000;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                produced = decode_byte(in_flight.data, in_flight.last, res);
                if (produced)
                    expected_results.push_back(res);
                bytes_sent++;
            end

            if (expected_results.size() != 0 || s_axis_tvalid)
                quiet_cycles = 0;
            else if (quiet_cycles < DRAIN_CYCLES)
                quiet_cycles++;

            // Hold an offered byte until it is taken.
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (src_gap == 0 && idling_allowed(bytes_sent) && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 7);
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (byte_stream.size() != 0 &&
                             !(byte_stream[0].hold_for_drain && quiet_cycles < DRAIN_CYCLES)) begin
                    in_flight = byte_stream.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.data;
                    s_axis_tlast  <= in_flight.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long sink hold-off: back the result side up so the input stalls
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : hold_results
        int hold_left;
        bit hold_done;
        if (!aresetn) begin
            hold_left = 0;
            hold_done = 1'b0;
            sink_hold <= 1'b0;
        end else if (!hold_done && bytes_sent >= HOLD_AT_BYTE) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
            sink_hold <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            sink_hold <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transaction with the oldest expectation
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch_results
        btlv_result_t want;
        int sink_gap;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, actual kind %0h tdata %0h last %0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, m_axis_tuser);
                    check_field("tag", want.tag, m_axis_tdata[15:0]);
                    check_field("tag_size", want.tag_size, m_axis_tdata[17:16]);
                    check_field("constructed", want.constructed, m_axis_tdata[18]);
                    check_field("value_length", want.value_length, m_axis_tdata[34:19]);
                    check_field("length_size", want.length_size, m_axis_tdata[36:35]);
                    check_field("value_out", want.value_out, m_axis_tdata[44:37]);
                    check_field("more_follows", want.more_follows, m_axis_tdata[45]);
                    check_field("element_end", want.element_end, m_axis_tlast);
                    check_field("tdata padding", 0, m_axis_tdata[47:46]);
                end
            end

            if (sink_gap == 0 && idling_allowed(bytes_sent) && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 7);
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !sink_hold;
            end
        end
    end

endmodule
